[design/seghit_pkg.sv]
// Shared constants and types for the segment hit or nearest point block.
`timescale 1ns / 1ps
`default_nettype none
package seghit_pkg;

  // Port widths of every coordinate and of the distance.
  localparam int unsigned IoWidth       = 32;
  localparam int unsigned DistWidth     = 33;

  // Defaults handed down from the top level.
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FifoDepthDef  = 4;

  // Queue status seen by both sides of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

[design/seghit_if.sv]
// Handshake channels for segment pair words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface seghit_req_if import seghit_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [IoWidth-1:0]  a_start_x;
  logic signed [IoWidth-1:0]  a_start_y;
  logic signed [IoWidth-1:0]  a_end_x;
  logic signed [IoWidth-1:0]  a_end_y;
  logic signed [IoWidth-1:0]  b_start_x;
  logic signed [IoWidth-1:0]  b_start_y;
  logic signed [IoWidth-1:0]  b_end_x;
  logic signed [IoWidth-1:0]  b_end_y;

  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface seghit_rsp_if import seghit_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [DistWidth-1:0]       distance;
  logic signed [IoWidth-1:0]  point_x;
  logic signed [IoWidth-1:0]  point_y;

  modport source (output valid, hit, distance, point_x, point_y, input ready);
  modport sink   (input valid, hit, distance, point_x, point_y, output ready);
endinterface
`default_nettype wire

[design/seghit_front.sv]
// Front part: forms cross products, classifies hit or fallback, queues the work.
`timescale 1ns / 1ps
`default_nettype none
module seghit_front import seghit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  seghit_req_if.sink                   req_i,
  input  fifo_stat_t                   stat_i,
  output logic                         push_o,
  output logic [10*COORD_WIDTH+4:0]    entry_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = 2 * CW + 1;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic signed [DW-1:0] step_x;
    logic signed [DW-1:0] step_y;
    logic [NW-1:0]        num;
    logic [NW-1:0]        den;
    logic signed [CW-1:0] org_x;
    logic signed [CW-1:0] org_y;
  } entry_t;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] e_x;
    logic signed [CW-1:0] e_y;
    logic signed [DW-1:0] s1x;
    logic signed [DW-1:0] s1y;
    logic signed [DW-1:0] s2x;
    logic signed [DW-1:0] s2y;
  } pts_t;

  function automatic logic signed [DW-1:0] sext(input logic [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [PW-1:0] aw;
    logic signed [PW-1:0] bw;
    aw = PW'(a);
    bw = PW'(b);
    return aw * bw;
  endfunction

  logic [3:0]           v_q;
  logic                 adv;
  pts_t                 p1_d, p1_q, p2_q, p3_q, p4_q;
  logic signed [DW-1:0] dx1_d, dy1_d, dx1_q, dy1_q;
  logic signed [PW-1:0] prod_q [10];
  logic signed [PW-1:0] den3_q, snum3_q, tnum3_q, l23_q, pnum3_q;
  logic signed [PW-1:0] den4_q, snum4_q, tnum4_q, l24_q, pnum4_q;
  logic                 nz4_q;
  entry_t               ent;

  // The whole front moves together unless a finished word cannot enter the queue.
  assign adv         = !v_q[3] || !stat_i.full;
  assign req_i.ready = adv;
  assign push_o      = v_q[3] && !stat_i.full;

  // First stage: sign-extend the inputs and take the segment differences.
  always_comb begin
    p1_d.a_x = req_i.a_start_x[CW-1:0];
    p1_d.a_y = req_i.a_start_y[CW-1:0];
    p1_d.c_x = req_i.b_start_x[CW-1:0];
    p1_d.c_y = req_i.b_start_y[CW-1:0];
    p1_d.e_x = req_i.b_end_x[CW-1:0];
    p1_d.e_y = req_i.b_end_y[CW-1:0];
    p1_d.s1x = sext(req_i.a_end_x[CW-1:0]) - sext(req_i.a_start_x[CW-1:0]);
    p1_d.s1y = sext(req_i.a_end_y[CW-1:0]) - sext(req_i.a_start_y[CW-1:0]);
    p1_d.s2x = sext(req_i.b_end_x[CW-1:0]) - sext(req_i.b_start_x[CW-1:0]);
    p1_d.s2y = sext(req_i.b_end_y[CW-1:0]) - sext(req_i.b_start_y[CW-1:0]);
    dx1_d    = sext(req_i.a_start_x[CW-1:0]) - sext(req_i.b_start_x[CW-1:0]);
    dy1_d    = sext(req_i.a_start_y[CW-1:0]) - sext(req_i.b_start_y[CW-1:0]);
  end

  // Valid bits of the four front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[2:0], req_i.valid};
    end
  end

  // Payload stages: products, sums, sign normalization.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q  <= p1_d;
      dx1_q <= dx1_d;
      dy1_q <= dy1_d;

      p2_q      <= p1_q;
      prod_q[0] <= smul(p1_q.s1x, p1_q.s2y);
      prod_q[1] <= smul(p1_q.s2x, p1_q.s1y);
      prod_q[2] <= smul(p1_q.s1x, dy1_q);
      prod_q[3] <= smul(p1_q.s1y, dx1_q);
      prod_q[4] <= smul(p1_q.s2x, dy1_q);
      prod_q[5] <= smul(p1_q.s2y, dx1_q);
      prod_q[6] <= smul(p1_q.s2x, p1_q.s2x);
      prod_q[7] <= smul(p1_q.s2y, p1_q.s2y);
      prod_q[8] <= smul(p1_q.s2x, dx1_q);
      prod_q[9] <= smul(p1_q.s2y, dy1_q);

      p3_q    <= p2_q;
      den3_q  <= prod_q[0] - prod_q[1];
      snum3_q <= prod_q[2] - prod_q[3];
      tnum3_q <= prod_q[4] - prod_q[5];
      l23_q   <= prod_q[6] + prod_q[7];
      pnum3_q <= prod_q[8] + prod_q[9];

      p4_q    <= p3_q;
      nz4_q   <= (den3_q != '0);
      den4_q  <= den3_q[PW-1] ? -den3_q  : den3_q;
      snum4_q <= den3_q[PW-1] ? -snum3_q : snum3_q;
      tnum4_q <= den3_q[PW-1] ? -tnum3_q : tnum3_q;
      l24_q   <= l23_q;
      pnum4_q <= pnum3_q;
    end
  end

  // Classify: crossing, or the nearest point of B as a scaled or fixed point.
  always_comb begin
    ent.hit = nz4_q && !snum4_q[PW-1] && (snum4_q <= den4_q) &&
              !tnum4_q[PW-1] && (tnum4_q <= den4_q);
    ent.step_x = p4_q.s2x;
    ent.step_y = p4_q.s2y;
    ent.base_x = p4_q.c_x;
    ent.base_y = p4_q.c_y;
    ent.num    = '0;
    ent.den    = NW'(1);
    ent.org_x  = p4_q.a_x;
    ent.org_y  = p4_q.a_y;
    if (ent.hit) begin
      ent.base_x = p4_q.a_x;
      ent.base_y = p4_q.a_y;
      ent.step_x = p4_q.s1x;
      ent.step_y = p4_q.s1y;
      ent.num    = tnum4_q[NW-1:0];
      ent.den    = den4_q[NW-1:0];
      ent.org_x  = p4_q.c_x;
      ent.org_y  = p4_q.c_y;
    end else if ((l24_q == '0) || pnum4_q[PW-1]) begin
      ent.base_x = p4_q.c_x;
      ent.base_y = p4_q.c_y;
    end else if (pnum4_q > l24_q) begin
      ent.base_x = p4_q.e_x;
      ent.base_y = p4_q.e_y;
    end else begin
      ent.num = pnum4_q[NW-1:0];
      ent.den = l24_q[NW-1:0];
    end
  end

  assign entry_o = ent;

endmodule
`default_nettype wire

[design/seghit_fifo.sv]
// Short queue that decouples the front part from the back part.
`timescale 1ns / 1ps
`default_nettype none
module seghit_fifo import seghit_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output fifo_stat_t       stat_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      count_q;

  assign stat_o.full  = (count_q == (AW+1)'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign data_o       = mem_q[rptr_q];

  // Storage is written at the write pointer.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[design/seghit_back.sv]
// Back part: scaled point by pipelined division, then distance by pipelined root.
`timescale 1ns / 1ps
`default_nettype none
module seghit_back import seghit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fifo_stat_t                   stat_i,
  input  logic [10*COORD_WIDTH+4:0]    entry_i,
  output logic                         pop_o,
  seghit_rsp_if.source                 rsp_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned NW = 2 * CW + 1;
  localparam int unsigned RB = CW + 1;
  localparam int unsigned RW = RB + 3;
  localparam int unsigned NB = 2 * CW + 8;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic signed [DW-1:0] step_x;
    logic signed [DW-1:0] step_y;
    logic [NW-1:0]        num;
    logic [NW-1:0]        den;
    logic signed [CW-1:0] org_x;
    logic signed [CW-1:0] org_y;
  } entry_t;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    logic [CW-1:0] org_x;
    logic [CW-1:0] org_y;
    logic          neg_x;
    logic          neg_y;
  } side_t;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  function automatic logic [NW+CW-1:0] div_step(input logic [NW-1:0] r,
                                                input logic [CW-1:0] l,
                                                input logic [NW-1:0] d);
    logic [NW:0] r2;
    logic [NW:0] df;
    logic        ge;
    r2 = {r, l[CW-1]};
    df = r2 - {1'b0, d};
    ge = (r2 >= {1'b0, d});
    return {(ge ? df[NW-1:0] : r2[NW-1:0]), l[CW-2:0], ge};
  endfunction

  // One digit of the square root: two radicand bits in, one root bit out.
  function automatic logic [RW+RB-1:0] sqrt_step(input logic [RW-1:0] rem,
                                                 input logic [RB-1:0] root,
                                                 input logic [1:0]    two);
    logic [RW-1:0] rem2;
    logic [RW-1:0] trial;
    logic          ge;
    rem2  = {rem[RW-3:0], two};
    trial = {1'b0, root, 2'b01};
    ge    = (rem2 >= trial);
    return {(ge ? rem2 - trial : rem2), root[RB-2:0], ge};
  endfunction

  function automatic logic [CW-1:0] absd(input logic [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? -v : v;
    return m[CW-1:0];
  endfunction

  entry_t        ent;
  logic          adv;
  logic [NB-1:0] vb_q;

  side_t          b1_side_q, b2_side_q;
  logic [CW-1:0]  b1_mx_q, b1_my_q;
  logic [NW-1:0]  b1_num_q, b1_den_q, b2_den_q;
  logic [2*CW-1:0] b2_lox_q, b2_loy_q;
  logic [2*CW:0]  b2_hix_q, b2_hiy_q;

  side_t          dv_side_q [CW+1];
  logic [NW-1:0]  dv_den_q  [CW+1];
  logic [NW-1:0]  dv_rx_q   [CW+1];
  logic [NW-1:0]  dv_ry_q   [CW+1];
  logic [CW-1:0]  dv_lx_q   [CW+1];
  logic [CW-1:0]  dv_ly_q   [CW+1];
  logic [3*CW:0]  prod_x, prod_y;

  side_t          pt_side_d;
  side_t          pt_side_q, ds_side_q, sq_side_q;
  logic [DW-1:0]  pt_sum_x, pt_sum_y;
  logic [CW-1:0]  ds_mx_q, ds_my_q;
  logic [2*CW-1:0] sq_x_q, sq_y_q;

  side_t          rt_side_q [RB+1];
  logic [RW-1:0]  rt_rem_q  [RB+1];
  logic [RB-1:0]  rt_root_q [RB+1];
  logic [2*RB-1:0] rt_n_q   [RB+1];

  logic                  vo_q;
  logic                  hit_q;
  logic [DistWidth-1:0]  dist_q;
  logic [CW-1:0]         px_q, py_q;

  assign ent   = entry_i;
  assign adv   = !vo_q || rsp_o.ready;
  assign pop_o = adv && !stat_i.empty;

  assign prod_x = {b2_hix_q, {CW{1'b0}}} + {{(CW+1){1'b0}}, b2_lox_q};
  assign prod_y = {b2_hiy_q, {CW{1'b0}}} + {{(CW+1){1'b0}}, b2_loy_q};

  // Point on the segment: base plus or minus the truncated quotient.
  assign pt_sum_x = {dv_side_q[CW].pos_x[CW-1], dv_side_q[CW].pos_x} +
                    (dv_side_q[CW].neg_x ? -{1'b0, dv_lx_q[CW]} : {1'b0, dv_lx_q[CW]});
  assign pt_sum_y = {dv_side_q[CW].pos_y[CW-1], dv_side_q[CW].pos_y} +
                    (dv_side_q[CW].neg_y ? -{1'b0, dv_ly_q[CW]} : {1'b0, dv_ly_q[CW]});

  // The final point replaces the base in the side data.
  always_comb begin
    pt_side_d       = dv_side_q[CW];
    pt_side_d.pos_x = pt_sum_x[CW-1:0];
    pt_side_d.pos_y = pt_sum_y[CW-1:0];
  end

  // Valid bits of all back stages, shifted as one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
      vo_q <= 1'b0;
    end else if (adv) begin
      vb_q <= {vb_q[NB-2:0], pop_o};
      vo_q <= vb_q[NB-1];
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Step magnitudes and signs.
      b1_side_q.hit   <= ent.hit;
      b1_side_q.pos_x <= ent.base_x;
      b1_side_q.pos_y <= ent.base_y;
      b1_side_q.org_x <= ent.org_x;
      b1_side_q.org_y <= ent.org_y;
      b1_side_q.neg_x <= ent.step_x[DW-1];
      b1_side_q.neg_y <= ent.step_y[DW-1];
      b1_mx_q         <= absd(ent.step_x);
      b1_my_q         <= absd(ent.step_y);
      b1_num_q        <= ent.num;
      b1_den_q        <= ent.den;

      // Numerator times step magnitude as two partial products.
      b2_side_q <= b1_side_q;
      b2_den_q  <= b1_den_q;
      b2_lox_q  <= b1_num_q[CW-1:0] * b1_mx_q;
      b2_loy_q  <= b1_num_q[CW-1:0] * b1_my_q;
      b2_hix_q  <= b1_num_q[NW-1:CW] * b1_mx_q;
      b2_hiy_q  <= b1_num_q[NW-1:CW] * b1_my_q;

      // Division pipeline: the quotient shifts in where dividend bits shift out.
      dv_side_q[0] <= b2_side_q;
      dv_den_q[0]  <= b2_den_q;
      dv_rx_q[0]   <= prod_x[3*CW:CW];
      dv_ry_q[0]   <= prod_y[3*CW:CW];
      dv_lx_q[0]   <= prod_x[CW-1:0];
      dv_ly_q[0]   <= prod_y[CW-1:0];
      for (int k = 1; k <= CW; k++) begin
        dv_side_q[k]             <= dv_side_q[k-1];
        dv_den_q[k]              <= dv_den_q[k-1];
        {dv_rx_q[k], dv_lx_q[k]} <= div_step(dv_rx_q[k-1], dv_lx_q[k-1], dv_den_q[k-1]);
        {dv_ry_q[k], dv_ly_q[k]} <= div_step(dv_ry_q[k-1], dv_ly_q[k-1], dv_den_q[k-1]);
      end

      // Final point.
      pt_side_q <= pt_side_d;

      // Distance components.
      ds_side_q <= pt_side_q;
      ds_mx_q   <= absd({pt_side_q.pos_x[CW-1], pt_side_q.pos_x} -
                        {pt_side_q.org_x[CW-1], pt_side_q.org_x});
      ds_my_q   <= absd({pt_side_q.pos_y[CW-1], pt_side_q.pos_y} -
                        {pt_side_q.org_y[CW-1], pt_side_q.org_y});

      // Squares.
      sq_side_q <= ds_side_q;
      sq_x_q    <= ds_mx_q * ds_mx_q;
      sq_y_q    <= ds_my_q * ds_my_q;

      // Square root pipeline.
      rt_side_q[0] <= sq_side_q;
      rt_rem_q[0]  <= '0;
      rt_root_q[0] <= '0;
      rt_n_q[0]    <= {2'b00, sq_x_q} + {2'b00, sq_y_q};
      for (int k = 1; k <= RB; k++) begin
        rt_side_q[k]                 <= rt_side_q[k-1];
        rt_n_q[k]                    <= {rt_n_q[k-1][2*RB-3:0], 2'b00};
        {rt_rem_q[k], rt_root_q[k]}  <= sqrt_step(rt_rem_q[k-1], rt_root_q[k-1],
                                                  rt_n_q[k-1][2*RB-1:2*RB-2]);
      end

      // Output register.
      hit_q  <= rt_side_q[RB].hit;
      dist_q <= DistWidth'(rt_root_q[RB]);
      px_q   <= rt_side_q[RB].pos_x;
      py_q   <= rt_side_q[RB].pos_y;
    end
  end

  assign rsp_o.valid    = vo_q;
  assign rsp_o.hit      = hit_q;
  assign rsp_o.distance = dist_q;
  assign rsp_o.point_x  = IoWidth'($signed(px_q));
  assign rsp_o.point_y  = IoWidth'($signed(py_q));

endmodule
`default_nettype wire

[design/segment_hit_or_nearest_point.sv]
// Top level: front classifier, decoupling queue and back arithmetic pipeline.
// Throughput: one word per cycle while neither part stalls.
// The division and square root are one bit per stage.
// The front stalls only when the queue is full, the back only when the result waits.
// Reset is asynchronous and active low; it clears valid bits and queue pointers.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module segment_hit_or_nearest_point import seghit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned FIFO_DEPTH  = FifoDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  seghit_req_if.sink     req_i,
  seghit_rsp_if.source   rsp_o
);

  localparam int unsigned EntryWidth = 10 * COORD_WIDTH + 5;

  logic                  push;
  logic                  pop;
  logic [EntryWidth-1:0] wr_entry;
  logic [EntryWidth-1:0] rd_entry;
  fifo_stat_t            stat;

  seghit_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .stat_i  (stat),
    .push_o  (push),
    .entry_o (wr_entry)
  );

  seghit_fifo #(
    .WIDTH (EntryWidth),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (wr_entry),
    .pop_i  (pop),
    .data_o (rd_entry),
    .stat_o (stat)
  );

  seghit_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .entry_i (rd_entry),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule
`default_nettype wire
